// File: rtl/ppmhp_pkg.sv
`default_nettype none

package ppmhp_pkg;

  localparam int unsigned DimW   = 16;
  localparam int unsigned AccW   = 16;
  localparam int unsigned ProdW  = 2 * DimW;
  localparam int unsigned LeftW  = ProdW + 2;

  localparam logic [7:0] ChP      = 8'h50;  // 'P'
  localparam logic [7:0] Ch6      = 8'h36;  // '6'
  localparam logic [7:0] ChLf     = 8'h0A;  // newline
  localparam logic [7:0] ChHash   = 8'h23;  // '#'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [AccW-1:0] MaxLimit = AccW'(255);

  typedef enum logic [3:0] {
    PH_M0, PH_M1, PH_M2, PH_C1, PH_C1L, PH_W, PH_H,
    PH_C2, PH_C2L, PH_MAX, PH_PIX, PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_NUMBER = 2'd2,
    ERR_RANGE  = 2'd3
  } err_t;

  typedef struct packed {
    phase_t            phase;
    logic [AccW-1:0]   acc;
    logic              seen;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [LeftW-1:0]  left;
  } state_t;

  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [7:0]      maxv;
    logic [7:0]      pix;
    err_t            err;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/ppm_p6_header_parser_top.sv
// Binary PPM (P6) header parser with pixel pass-through.
// Input channel: one stream byte per item on in_byte, in_valid/in_stall.
// Output channel: one result item per accepted byte at most, on kind and
// the field ports, out_valid/out_stall. kind: header, pixel or error.
// A header item carries width, height and max value; "last" flags the
// final pixel byte, or a header whose image holds no pixels.
// A result is registered and is on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall is low; the whole header/number/pixel update
// is one pass of logic between the state register and the output register.
// w*h is formed in a product register from the stored width and height;
// at least two bytes always separate the height from the header, so the
// product is settled when it is used.
// Stall: in_stall rises only while a result waits and out_stall is high.
// After an error the block swallows all bytes with no result until reset.
// Reset (rst, synchronous): back to expecting the 'P' of a new image,
// output empty. After a complete image the next magic is expected.
`default_nettype none

module ppm_p6_header_parser_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] kind,
  output logic [15:0] img_width,
  output logic [15:0] img_height,
  output logic [7:0] max_value,
  output logic [7:0] pixel_byte,
  output logic [1:0] error_code,
  output logic       last
);
  import ppmhp_pkg::*;

  state_t           st;
  state_t           st_next;
  result_t          res;
  logic [ProdW-1:0] prod;
  logic             accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  ppmhp_step u_step (
    .cur     (st),
    .in_byte (in_byte),
    .prod    (prod),
    .nxt     (st_next),
    .res     (res)
  );

  // pixel count factor, registered from the dimension registers
  always_ff @(posedge clk) begin
    prod <= ProdW'(st.width) * ProdW'(st.height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= PH_M0;
      st.acc    <= '0;
      st.seen   <= 1'b0;
      st.width  <= '0;
      st.height <= '0;
      st.left   <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      kind       <= res.kind;
      img_width  <= res.width;
      img_height <= res.height;
      max_value  <= res.maxv;
      pixel_byte <= res.pix;
      error_code <= res.err;
      last       <= res.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ppmhp_step.sv
`default_nettype none

module ppmhp_step (
  input  wire ppmhp_pkg::state_t                  cur,
  input  wire [7:0]                               in_byte,
  input  wire [2*ppmhp_pkg::DimW-1:0]             prod,
  output ppmhp_pkg::state_t                       nxt,
  output ppmhp_pkg::result_t                      res
);
  import ppmhp_pkg::*;

  logic            is_digit;
  logic            is_ws;
  logic [3:0]      dval;
  logic [19:0]     acc_x10;
  logic [19:0]     acc_new;
  logic            ovf;
  logic [LeftW-1:0] total;
  logic [LeftW-1:0] left_dec;

  assign is_digit = (in_byte >= ChZero) && (in_byte <= ChNine);
  assign is_ws    = (in_byte == ChSpace) || ((in_byte >= ChTab) && (in_byte <= ChCr));
  assign dval     = 4'(in_byte - ChZero);
  assign acc_x10  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
  assign acc_new  = acc_x10 + {16'd0, dval};
  assign ovf      = |acc_new[19:16];
  // samples = w*h*3
  assign total    = {2'b00, prod} + {1'b0, prod, 1'b0};
  assign left_dec = (cur.left == '0) ? '0 : cur.left - LeftW'(1);

  always_comb begin
    nxt = cur;
    res = '0;

    unique case (cur.phase)
      PH_M0: begin
        if (in_byte == ChP) nxt.phase = PH_M1;
        else begin
          nxt.phase = PH_ERR;
          res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_MAGIC;
        end
      end
      PH_M1: begin
        if (in_byte == Ch6) nxt.phase = PH_M2;
        else begin
          nxt.phase = PH_ERR;
          res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_MAGIC;
        end
      end
      PH_M2: begin
        if (in_byte == ChLf) nxt.phase = PH_C1;
        else begin
          nxt.phase = PH_ERR;
          res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_MAGIC;
        end
      end
      PH_C1L: if (in_byte == ChLf) nxt.phase = PH_C1;
      PH_C2L: if (in_byte == ChLf) nxt.phase = PH_C2;
      PH_C1, PH_C2, PH_W, PH_H, PH_MAX: begin
        // comment check first where the phase allows one
        if ((cur.phase == PH_C1 || cur.phase == PH_C2) && in_byte == ChHash) begin
          nxt.phase = (cur.phase == PH_C1) ? PH_C1L : PH_C2L;
        end else if (is_digit) begin
          // acc is zero coming out of a comment phase
          if (cur.phase == PH_C1) nxt.phase = PH_W;
          if (cur.phase == PH_C2) nxt.phase = PH_MAX;
          if (ovf) begin
            nxt.phase = PH_ERR; nxt.acc = '0; nxt.seen = 1'b0;
            res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_NUMBER;
          end else begin
            nxt.acc  = acc_new[AccW-1:0];
            nxt.seen = 1'b1;
          end
        end else if (!cur.seen || cur.phase == PH_C1 || cur.phase == PH_C2) begin
          // leading position: whitespace skipped, anything else is bad
          if (is_ws) begin
            if (cur.phase == PH_C1) nxt.phase = PH_W;
            if (cur.phase == PH_C2) nxt.phase = PH_MAX;
          end else begin
            nxt.phase = PH_ERR; nxt.acc = '0; nxt.seen = 1'b0;
            res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_NUMBER;
          end
        end else begin
          // number ends on a non-digit
          nxt.acc  = '0;
          nxt.seen = 1'b0;
          priority case (cur.phase)
            PH_W: begin
              nxt.width = cur.acc;
              // terminator goes to height: only whitespace is legal
              if (is_ws) nxt.phase = PH_H;
              else begin
                nxt.phase = PH_ERR;
                res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_NUMBER;
              end
            end
            PH_H: begin
              nxt.height = cur.acc;
              if (in_byte == ChHash) nxt.phase = PH_C2L;
              else if (is_ws) nxt.phase = PH_MAX;
              else begin
                nxt.phase = PH_ERR;
                res.valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_NUMBER;
              end
            end
            default: begin
              // separator after maximum value
              res.valid = 1'b1;
              if (cur.acc > MaxLimit) begin
                nxt.phase = PH_ERR;
                res.kind  = KIND_ERROR; res.err = ERR_RANGE;
              end else begin
                nxt.left   = total;
                nxt.phase  = (prod == '0) ? PH_M0 : PH_PIX;
                res.kind   = KIND_HEADER;
                res.width  = cur.width;
                res.height = cur.height;
                res.maxv   = cur.acc[7:0];
                res.last   = (prod == '0);
              end
            end
          endcase
        end
      end
      PH_PIX: begin
        nxt.left  = left_dec;
        if (left_dec == '0) nxt.phase = PH_M0;
        res.valid = 1'b1;
        res.kind  = KIND_PIXEL;
        res.pix   = in_byte;
        res.last  = (left_dec == '0);
      end
      PH_ERR: ;
      default: nxt.phase = PH_M0;
    endcase
  end

endmodule

`default_nettype wire
